FILE: sv/bpc_pkg.sv
// Shared widths, constants and types of the pressure compensation block.
`default_nettype none

package bpc_pkg;

    // Port field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int IDX_W   = 3;
    localparam int PRESS_W = 32;
    localparam int TEMP_W  = 19;

    // Internal widths, sized to the value ranges of each intermediate
    localparam int DT_W   = 25;   // raw temperature minus reference
    localparam int MUL_W  = 42;   // dT times a 16-bit coefficient
    localparam int SQ_W   = 50;   // dT squared
    localparam int T_W    = 20;   // temperature with headroom for the cold deltas
    localparam int OC_W   = 40;   // offset, sensitivity and their corrections
    localparam int LO_W   = 20;   // low slice of sensitivity for the split product
    localparam int PP_W   = 44;   // partial products of pressure times sensitivity
    localparam int PROD_W = 64;   // full pressure times sensitivity
    localparam int Q_W    = 44;   // scaled product minus offset

    // Shift amounts of the compensation formulas
    localparam int TREF_SHIFT    = 8;
    localparam int TEMP_SHIFT    = 23;
    localparam int OFF_C_SHIFT   = 16;
    localparam int OFF_TC_SHIFT  = 7;
    localparam int SENS_C_SHIFT  = 15;
    localparam int SENS_TC_SHIFT = 8;
    localparam int DT_SQ_SHIFT   = 31;
    localparam int PROD_SHIFT    = 21;
    localparam int P_SHIFT       = 15;

    // Temperature thresholds in hundredths of a degree
    localparam logic signed [T_W-1:0] TEMP_REF    = 20'sd2000;
    localparam logic signed [T_W-1:0] VCOLD_LIMIT = -20'sd1500;

    // Register stages from input to output register
    localparam int PIPE_DEPTH = 8;

    // Calibration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SENS      = 3'd0,
        REG_OFFSET    = 3'd1,
        REG_SENS_TC   = 3'd2,
        REG_OFFSET_TC = 3'd3,
        REG_TREF      = 3'd4,
        REG_TEMP_SENS = 3'd5
    } bpc_reg_t;

    // Calibration words as seen by the datapath
    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] offset;
        logic [COEF_W-1:0] sens_tc;
        logic [COEF_W-1:0] offset_tc;
        logic [COEF_W-1:0] tref;
        logic [COEF_W-1:0] temp_sens;
    } bpc_coeff_t;

    // Pipeline control from the top level
    typedef struct packed {
        logic advance;   // all stages move one step
        logic load;      // an item enters stage one
    } bpc_ctl_t;

endpackage

`default_nettype wire

FILE: sv/bpc_if.sv
// Channel interfaces: raw sample items, result items and calibration writes.
`default_nettype none

interface bpc_sample_if;
    import bpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] pressure_raw;
    logic [RAW_W-1:0] temperature_raw;
    modport source (output valid, output pressure_raw, output temperature_raw, input ready);
    modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bpc_result_if;
    import bpc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [PRESS_W-1:0] pressure_pa;
    logic signed [TEMP_W-1:0]  temperature_centi;
    modport source (output valid, output pressure_pa, output temperature_centi, input ready);
    modport sink   (input valid, input pressure_pa, input temperature_centi, output ready);
endinterface

interface bpc_cfg_if;
    import bpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [COEF_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/bpc_pipe.sv
// Eight-stage compensation datapath with valid bits and a common stall.
`default_nettype none

module bpc_pipe (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bpc_pkg::bpc_ctl_t                  ctl,
    input  wire bpc_pkg::bpc_coeff_t                coeff,
    input  wire logic [bpc_pkg::RAW_W-1:0]          pressure_raw,
    input  wire logic [bpc_pkg::RAW_W-1:0]          temperature_raw,
    output logic                                    out_valid,
    output logic signed [bpc_pkg::PRESS_W-1:0]      pressure_pa,
    output logic signed [bpc_pkg::TEMP_W-1:0]       temperature_centi
);
    import bpc_pkg::*;

    // Valid bits, one per stage
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    // Stage 1: temperature difference
    logic [RAW_W-1:0]       s1_d1_reg;
    logic signed [DT_W-1:0] s1_dt_reg, s1_dt_next;

    // Stage 2: products with dT
    logic [RAW_W-1:0]        s2_d1_reg;
    logic signed [MUL_W-1:0] s2_pt_reg, s2_pt_next;
    logic signed [MUL_W-1:0] s2_po_reg, s2_po_next;
    logic signed [MUL_W-1:0] s2_ps_reg, s2_ps_next;
    logic signed [SQ_W-1:0]  s2_sq_reg, s2_sq_next;

    // Stage 3: first-order temperature, offset, sensitivity
    logic [RAW_W-1:0]       s3_d1_reg;
    logic signed [T_W-1:0]  s3_temp_reg, s3_temp_next;
    logic signed [OC_W-1:0] s3_off_reg, s3_off_next;
    logic signed [OC_W-1:0] s3_sens_reg, s3_sens_next;
    logic signed [T_W-1:0]  s3_tcorr_reg, s3_tcorr_next;

    // Stage 4: cold flags and squares
    logic [RAW_W-1:0]       s4_d1_reg;
    logic signed [T_W-1:0]  s4_temp_reg, s4_temp_next;
    logic signed [OC_W-1:0] s4_off_reg;
    logic signed [OC_W-1:0] s4_sens_reg;
    logic                   s4_cold_reg, s4_cold_next;
    logic                   s4_vcold_reg, s4_vcold_next;
    logic signed [OC_W-1:0] s4_dsq_reg, s4_dsq_next;
    logic signed [OC_W-1:0] s4_esq_reg, s4_esq_next;
    logic signed [T_W-1:0]  d_s4, e_s4;

    // Stage 5: second-order corrections applied
    logic [RAW_W-1:0]       s5_d1_reg;
    logic signed [T_W-1:0]  s5_temp_reg;
    logic signed [OC_W-1:0] s5_off_reg, s5_off_next;
    logic signed [OC_W-1:0] s5_sens_reg, s5_sens_next;
    logic signed [OC_W-1:0] five_d, seven_e, eleven_e;
    logic signed [OC_W-1:0] off_cold, sens_cold, off_vcold, sens_vcold;

    // Stage 6: split pressure times sensitivity
    logic signed [T_W-1:0]  s6_temp_reg;
    logic signed [OC_W-1:0] s6_off_reg;
    logic [PP_W-1:0]        s6_pl_reg, s6_pl_next;
    logic signed [PP_W-1:0] s6_ph_reg, s6_ph_next;
    logic [LO_W-1:0]        sens_lo;
    logic signed [OC_W-LO_W-1:0] sens_hi;

    // Stage 7: recombined product
    logic signed [T_W-1:0]    s7_temp_reg;
    logic signed [OC_W-1:0]   s7_off_reg;
    logic signed [PROD_W-1:0] s7_prod_reg, s7_prod_next;

    // Stage 8: output register
    logic signed [PRESS_W-1:0] s8_press_reg, s8_press_next;
    logic signed [TEMP_W-1:0]  s8_temp_reg, s8_temp_next;
    logic signed [Q_W-1:0]     q_s8;

    // Valid bits shift with the data
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], ctl.load};

    // Stage 1 logic
    assign s1_dt_next = $signed({1'b0, temperature_raw})
                      - $signed(DT_W'(coeff.tref) << TREF_SHIFT);

    // Stage 2 logic: four independent multipliers
    assign s2_pt_next = s1_dt_reg * $signed({1'b0, coeff.temp_sens});
    assign s2_po_next = s1_dt_reg * $signed({1'b0, coeff.offset_tc});
    assign s2_ps_next = s1_dt_reg * $signed({1'b0, coeff.sens_tc});
    assign s2_sq_next = s1_dt_reg * s1_dt_reg;

    // Stage 3 logic
    assign s3_temp_next  = TEMP_REF + T_W'(s2_pt_reg >>> TEMP_SHIFT);
    assign s3_off_next   = $signed(OC_W'(coeff.offset) << OFF_C_SHIFT)
                         + OC_W'(s2_po_reg >>> OFF_TC_SHIFT);
    assign s3_sens_next  = $signed(OC_W'(coeff.sens) << SENS_C_SHIFT)
                         + OC_W'(s2_ps_reg >>> SENS_TC_SHIFT);
    assign s3_tcorr_next = T_W'(s2_sq_reg >>> DT_SQ_SHIFT);

    // Stage 4 logic: thresholds are tested on the first-order temperature
    assign d_s4          = s3_temp_reg - TEMP_REF;
    assign e_s4          = s3_temp_reg - VCOLD_LIMIT;
    assign s4_cold_next  = s3_temp_reg < TEMP_REF;
    assign s4_vcold_next = s3_temp_reg < VCOLD_LIMIT;
    assign s4_dsq_next   = OC_W'(d_s4) * OC_W'(d_s4);
    assign s4_esq_next   = OC_W'(e_s4) * OC_W'(e_s4);
    assign s4_temp_next  = s4_cold_next ? (s3_temp_reg - s3_tcorr_reg) : s3_temp_reg;

    // Stage 5 logic: constant multiples by shifts, adds and a subtract
    assign five_d     = (s4_dsq_reg <<< 2) + s4_dsq_reg;
    assign seven_e    = (s4_esq_reg <<< 3) - s4_esq_reg;
    assign eleven_e   = (s4_esq_reg <<< 3) + (s4_esq_reg <<< 1) + s4_esq_reg;
    assign off_cold   = s4_cold_reg  ? (five_d >>> 1)   : '0;
    assign sens_cold  = s4_cold_reg  ? (five_d >>> 2)   : '0;
    assign off_vcold  = s4_vcold_reg ? seven_e          : '0;
    assign sens_vcold = s4_vcold_reg ? (eleven_e >>> 1) : '0;
    assign s5_off_next  = s4_off_reg - off_cold - off_vcold;
    assign s5_sens_next = s4_sens_reg - sens_cold - sens_vcold;

    // Stage 6 logic: low slice unsigned, high slice signed
    assign sens_lo    = s5_sens_reg[LO_W-1:0];
    assign sens_hi    = s5_sens_reg[OC_W-1:LO_W];
    assign s6_pl_next = PP_W'(s5_d1_reg) * PP_W'(sens_lo);
    assign s6_ph_next = $signed({1'b0, s5_d1_reg}) * sens_hi;

    // Stage 7 logic
    assign s7_prod_next = (PROD_W'(s6_ph_reg) <<< LO_W) + $signed(PROD_W'(s6_pl_reg));

    // Stage 8 logic: result stays well inside 32 bits for any input
    assign q_s8          = Q_W'(s7_prod_reg >>> PROD_SHIFT) - Q_W'(s7_off_reg);
    assign s8_press_next = PRESS_W'(q_s8 >>> P_SHIFT);
    assign s8_temp_next  = TEMP_W'(s7_temp_reg);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.advance)
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            s1_d1_reg    <= pressure_raw;
            s1_dt_reg    <= s1_dt_next;

            s2_d1_reg    <= s1_d1_reg;
            s2_pt_reg    <= s2_pt_next;
            s2_po_reg    <= s2_po_next;
            s2_ps_reg    <= s2_ps_next;
            s2_sq_reg    <= s2_sq_next;

            s3_d1_reg    <= s2_d1_reg;
            s3_temp_reg  <= s3_temp_next;
            s3_off_reg   <= s3_off_next;
            s3_sens_reg  <= s3_sens_next;
            s3_tcorr_reg <= s3_tcorr_next;

            s4_d1_reg    <= s3_d1_reg;
            s4_temp_reg  <= s4_temp_next;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_cold_reg  <= s4_cold_next;
            s4_vcold_reg <= s4_vcold_next;
            s4_dsq_reg   <= s4_dsq_next;
            s4_esq_reg   <= s4_esq_next;

            s5_d1_reg    <= s4_d1_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_off_reg   <= s5_off_next;
            s5_sens_reg  <= s5_sens_next;

            s6_temp_reg  <= s5_temp_reg;
            s6_off_reg   <= s5_off_reg;
            s6_pl_reg    <= s6_pl_next;
            s6_ph_reg    <= s6_ph_next;

            s7_temp_reg  <= s6_temp_reg;
            s7_off_reg   <= s6_off_reg;
            s7_prod_reg  <= s7_prod_next;

            s8_press_reg <= s8_press_next;
            s8_temp_reg  <= s8_temp_next;
        end
    end

    assign out_valid         = vld_reg[PIPE_DEPTH-1];
    assign pressure_pa       = s8_press_reg;
    assign temperature_centi = s8_temp_reg;

endmodule

`default_nettype wire

FILE: sv/barometric_pressure_compensation.sv
// Top level: calibration registers, stall control and the compensation pipeline.
//
// Usage:
//   sample  - sink channel; one item carries a raw pressure and a raw temperature
//             conversion. Accepted when valid and ready are both high.
//   result  - source channel; one item per sample: pressure in Pa (signed 32)
//             and temperature in hundredths of a degree (signed 19).
//   cfg     - calibration writes, index 0..5 selects the word, others are
//             dropped. Always ready; write only while no items are in flight.
// A sample passes from accept to result valid through the eight register
// stages of the datapath (subtract, multiply, combine, square, correct,
// split multiply, recombine, output). Throughput is one item per cycle while
// the receiver keeps ready high.
// When a result waits with ready low, every stage holds and sample.ready drops
// in the same cycle; nothing is lost or repeated, and bubbles move freely
// whenever the output register is empty.
// Reset (rst_n low) clears all calibration words to zero and empties the
// pipeline.
`default_nettype none

module barometric_pressure_compensation (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bpc_sample_if.sink   sample,
    bpc_result_if.source result,
    bpc_cfg_if.sink      cfg
);
    import bpc_pkg::*;

    bpc_coeff_t coeff_reg, coeff_next;
    bpc_ctl_t   ctl;
    logic       out_valid;

    // Calibration register write
    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg.valid)
        begin
            case (bpc_reg_t'(cfg.index))
                REG_SENS:      coeff_next.sens      = cfg.data;
                REG_OFFSET:    coeff_next.offset    = cfg.data;
                REG_SENS_TC:   coeff_next.sens_tc   = cfg.data;
                REG_OFFSET_TC: coeff_next.offset_tc = cfg.data;
                REG_TREF:      coeff_next.tref      = cfg.data;
                REG_TEMP_SENS: coeff_next.temp_sens = cfg.data;
                default:       coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Whole pipeline moves unless a finished item is held by the receiver
    assign ctl.advance  = !out_valid || result.ready;
    assign ctl.load     = sample.valid;
    assign sample.ready = ctl.advance;

    bpc_pipe u_pipe (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .coeff             (coeff_reg),
        .pressure_raw      (sample.pressure_raw),
        .temperature_raw   (sample.temperature_raw),
        .out_valid         (out_valid),
        .pressure_pa       (result.pressure_pa),
        .temperature_centi (result.temperature_centi)
    );

    assign result.valid = out_valid;

endmodule

`default_nettype wire

FILE: sv/bpc_checker.sv
// Port-level checks of the compensation block, bound to its top level.
`default_nettype none

module bpc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              sample_valid,
    input wire logic                              sample_ready,
    input wire logic                              result_valid,
    input wire logic                              result_ready,
    input wire logic [bpc_pkg::PRESS_W-1:0]       pressure_pa,
    input wire logic [bpc_pkg::TEMP_W-1:0]        temperature_centi
);
    import bpc_pkg::*;

    // Recent accept and ready history
    logic [PIPE_DEPTH-1:0] acc_hist_reg;
    logic [PIPE_DEPTH-2:0] rdy_hist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_hist_reg <= '0;
            rdy_hist_reg <= '0;
        end
        else
        begin
            acc_hist_reg <= {acc_hist_reg[PIPE_DEPTH-2:0], sample_valid && sample_ready};
            rdy_hist_reg <= {rdy_hist_reg[PIPE_DEPTH-3:0], result_ready};
        end
    end

    // A held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(pressure_pa) && $stable(temperature_centi))
        else $error("result changed while stalled");

    // A held result stalls the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !sample_ready)
        else $error("sample taken while output stalled");

    // An empty output register never blocks input
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input blocked with output empty");

    // Fixed latency with an unstalled receiver
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc_hist_reg[PIPE_DEPTH-1] && (&rdy_hist_reg) |-> result_valid)
        else $error("result missing after pipeline latency");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .sample_valid      (sample.valid),
    .sample_ready      (sample.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .pressure_pa       (result.pressure_pa),
    .temperature_centi (result.temperature_centi)
);

`default_nettype wire
